[hdl/pfs_pkg.sv]
// shared types and constants of the phong fragment shader
`default_nettype none

package pfs_pkg;

    // three vector components, 17 bit signed each, kept unsigned in the packed array
    typedef logic [2:0][16:0] t_vec;
    typedef logic [2:0][7:0]  t_rgb;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         tex_r;
        logic [7:0]         tex_g;
        logic [7:0]         tex_b;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg_word;

    typedef enum logic [2:0] {
        REG_EYE_X   = 3'd0,
        REG_EYE_Y   = 3'd1,
        REG_EYE_Z   = 3'd2,
        REG_LIGHT_X = 3'd3,
        REG_LIGHT_Y = 3'd4,
        REG_LIGHT_Z = 3'd5
    } t_reg_idx;

    localparam logic [15:0] LIGHT_Z_RESET = 16'd1280;
    localparam int Q15_ONE        = 32768;
    localparam int AMBIENT_Q15    = 3277;
    localparam int DIFF_GAIN_Q15  = 26214;
    localparam int ATTEN_DIV      = 162;
    localparam int ATTEN_LIMIT    = Q15_ONE * ATTEN_DIV;
    // floor(2^32 / 162)
    localparam int ATTEN_RECIP    = 26512143;
    localparam int SPEC_SQUARINGS = 7;
    localparam int ROUND_Q15      = 16384;
    localparam int NORM_LAT       = 45;

endpackage

`default_nettype wire

[hdl/pfs_chan_if.sv]
// valid/ready channel carrying one word of type T
`default_nettype none

interface pfs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/phong_fragment_shade_top.sv]
// phong fragment shader: point light diffuse with attenuation, specular power 128
//
// channels: i_in takes one fragment word (normal Q2.14, position Q8.8, texel rgb),
// o_out gives one shaded rgb word per fragment, in order. i_cfg writes the eye and
// light position registers by index; it is always ready and is meant to be used
// while no fragment is in flight.
// throughput is one word per cycle while o_out takes its words: the path is a
// fixed pipeline whose longest parts are the 25-stage square root and the 16-stage
// divide in each of the three normalizers.
// stall: the whole pipeline advances when the output register is empty or taken;
// when the receiver holds ready low with a word waiting, every stage holds and
// i_in.ready goes low, so nothing is lost or repeated.
// reset: clears all valid bits and loads eye (0,0,0) and light (0,0,5.0).
// a zero normal or a fragment at the light leaves only the ambient term; a
// fragment at the eye drops the specular term.
`default_nettype none

module phong_fragment_shade_top (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    pfs_chan_if.sink   i_in,
    pfs_chan_if.source o_out,
    pfs_chan_if.sink   i_cfg
);

    localparam int Lat       = 62;
    localparam int IdxUnit   = pfs_pkg::NORM_LAT;
    localparam int IdxP6     = IdxUnit + 6;
    localparam int IdxP9     = IdxUnit + 9;
    localparam int IdxP14    = IdxUnit + 14;
    localparam int Sq        = pfs_pkg::SPEC_SQUARINGS;

    // configuration registers
    logic signed [15:0] r_eye   [3];
    logic signed [15:0] r_light [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye[0]   <= '0;
            r_eye[1]   <= '0;
            r_eye[2]   <= '0;
            r_light[0] <= '0;
            r_light[1] <= '0;
            r_light[2] <= pfs_pkg::LIGHT_Z_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                pfs_pkg::REG_EYE_X:   r_eye[0]   <= i_cfg.data.value;
                pfs_pkg::REG_EYE_Y:   r_eye[1]   <= i_cfg.data.value;
                pfs_pkg::REG_EYE_Z:   r_eye[2]   <= i_cfg.data.value;
                pfs_pkg::REG_LIGHT_X: r_light[0] <= i_cfg.data.value;
                pfs_pkg::REG_LIGHT_Y: r_light[1] <= i_cfg.data.value;
                pfs_pkg::REG_LIGHT_Z: r_light[2] <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic en;
    logic r_vld [Lat];

    assign en         = !r_vld[Lat-1] || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Lat; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int i = 1; i < Lat; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // input stage: vectors to light and eye
    logic signed [15:0] pos [3];
    pfs_pkg::t_vec n_nrm, n_lv, n_ev;
    pfs_pkg::t_vec r_nrm, r_lv, r_ev;
    pfs_pkg::t_rgb r_tex0;

    always_comb begin
        pos[0]   = i_in.data.pos_x;
        pos[1]   = i_in.data.pos_y;
        pos[2]   = i_in.data.pos_z;
        n_nrm[0] = 17'(i_in.data.normal_x);
        n_nrm[1] = 17'(i_in.data.normal_y);
        n_nrm[2] = 17'(i_in.data.normal_z);
        for (int c = 0; c < 3; c++) begin
            n_lv[c] = 17'(r_light[c]) - 17'(pos[c]);
            n_ev[c] = 17'(r_eye[c]) - 17'(pos[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nrm     <= n_nrm;
            r_lv      <= n_lv;
            r_ev      <= n_ev;
            r_tex0[0] <= i_in.data.tex_r;
            r_tex0[1] <= i_in.data.tex_g;
            r_tex0[2] <= i_in.data.tex_b;
        end
    end

    // normalizers
    pfs_pkg::t_vec n_u, l_u, v_u;
    logic [33:0]   n_sum, l_sum, v_sum;

    pfs_norm u_norm_n (.i_clk(i_clk), .i_en(en), .i_a(r_nrm), .o_u(n_u), .o_sum(n_sum));
    pfs_norm u_norm_l (.i_clk(i_clk), .i_en(en), .i_a(r_lv),  .o_u(l_u), .o_sum(l_sum));
    pfs_norm u_norm_v (.i_clk(i_clk), .i_en(en), .i_a(r_ev),  .o_u(v_u), .o_sum(v_sum));

    pfs_pkg::t_rgb r_texd [IdxUnit];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_texd[0] <= r_tex0;
            for (int i = 1; i < IdxUnit; i++) begin
                r_texd[i] <= r_texd[i-1];
            end
        end
    end

    // p1: n.l products, attenuation reciprocal multiply
    logic signed [33:0] nl [3];
    logic [47:0]        pm;
    logic signed [33:0] r_p1_nl [3];
    pfs_pkg::t_vec      r_p1_n, r_p1_l, r_p1_v;
    logic               r_p1_okd, r_p1_oks, r_p1_far;
    pfs_pkg::t_rgb      r_p1_tex;
    logic [22:0]        r_p1_x;
    logic [47:0]        r_p1_pm;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nl[c] = $signed(n_u[c]) * $signed(l_u[c]);
        end
        pm = {25'b0, l_sum[22:0]} * 48'(pfs_pkg::ATTEN_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_nl  <= nl;
            r_p1_n   <= n_u;
            r_p1_l   <= l_u;
            r_p1_v   <= v_u;
            r_p1_okd <= (n_sum != '0) && (l_sum != '0);
            r_p1_oks <= (n_sum != '0) && (l_sum != '0) && (v_sum != '0);
            r_p1_far <= l_sum >= 34'(pfs_pkg::ATTEN_LIMIT);
            r_p1_x   <= l_sum[22:0];
            r_p1_pm  <= pm;
            r_p1_tex <= r_texd[IdxUnit-1];
        end
    end

    // p2: n.l sum, quotient estimate
    logic signed [34:0] r_p2_dnl;
    pfs_pkg::t_vec      r_p2_n, r_p2_l, r_p2_v;
    logic               r_p2_okd, r_p2_oks, r_p2_far;
    pfs_pkg::t_rgb      r_p2_tex;
    logic [22:0]        r_p2_x;
    logic [15:0]        r_p2_q0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_dnl <= 35'(r_p1_nl[0]) + 35'(r_p1_nl[1]) + 35'(r_p1_nl[2]);
            r_p2_q0  <= r_p1_pm[47:32];
            r_p2_n   <= r_p1_n;
            r_p2_l   <= r_p1_l;
            r_p2_v   <= r_p1_v;
            r_p2_okd <= r_p1_okd;
            r_p2_oks <= r_p1_oks;
            r_p2_far <= r_p1_far;
            r_p2_x   <= r_p1_x;
            r_p2_tex <= r_p1_tex;
        end
    end

    // p3: reflect products, diffuse clamp, quotient check product
    logic signed [52:0] tr [3];
    logic [15:0]        diff;
    logic signed [52:0] r_p3_t [3];
    logic [15:0]        r_p3_diff;
    logic [23:0]        r_p3_q0m;
    logic [15:0]        r_p3_q0;
    logic [22:0]        r_p3_x;
    logic               r_p3_far, r_p3_oks;
    pfs_pkg::t_vec      r_p3_l, r_p3_v;
    pfs_pkg::t_rgb      r_p3_tex;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tr[c] = (53'(r_p2_dnl) * 53'($signed(r_p2_n[c]))) <<< 1;
        end
        if (!r_p2_okd || r_p2_dnl <= 0) begin
            diff = '0;
        end else if (r_p2_dnl[34:15] > 20'(pfs_pkg::Q15_ONE)) begin
            diff = 16'(pfs_pkg::Q15_ONE);
        end else begin
            diff = r_p2_dnl[30:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_t    <= tr;
            r_p3_diff <= diff;
            r_p3_q0m  <= 24'(r_p2_q0) * 24'(pfs_pkg::ATTEN_DIV);
            r_p3_q0   <= r_p2_q0;
            r_p3_x    <= r_p2_x;
            r_p3_far  <= r_p2_far;
            r_p3_oks  <= r_p2_oks;
            r_p3_l    <= r_p2_l;
            r_p3_v    <= r_p2_v;
            r_p3_tex  <= r_p2_tex;
        end
    end

    // p4: reflect vector, attenuation base
    logic signed [22:0] tq [3];
    logic signed [23:0] rr [3];
    logic [23:0]        arem;
    logic [15:0]        aq;
    logic [15:0]        abase;
    logic signed [23:0] r_p4_r [3];
    logic [15:0]        r_p4_ab, r_p4_diff;
    logic               r_p4_oks;
    pfs_pkg::t_vec      r_p4_v;
    pfs_pkg::t_rgb      r_p4_tex;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // divide by 2^30 rounding toward zero
            tq[c] = 23'(r_p3_t[c] >>> 30);
            if (r_p3_t[c][52] && (r_p3_t[c][29:0] != '0)) begin
                tq[c] = tq[c] + 23'sd1;
            end
            rr[c] = 24'(tq[c]) - 24'($signed(r_p3_l[c]));
        end
        arem = 24'(r_p3_x) - r_p3_q0m;
        aq   = (arem >= 24'(pfs_pkg::ATTEN_DIV)) ? r_p3_q0 + 16'd1 : r_p3_q0;
        if (r_p3_far) begin
            abase = '0;
        end else begin
            abase = 16'(17'(pfs_pkg::Q15_ONE) - {1'b0, aq});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_r    <= rr;
            r_p4_ab   <= abase;
            r_p4_diff <= r_p3_diff;
            r_p4_oks  <= r_p3_oks;
            r_p4_v    <= r_p3_v;
            r_p4_tex  <= r_p3_tex;
        end
    end

    // p5: r.v products, attenuation square
    logic signed [40:0] rv [3];
    logic signed [40:0] r_p5_rv [3];
    logic [31:0]        r_p5_ab2;
    logic [15:0]        r_p5_diff;
    logic               r_p5_oks;
    pfs_pkg::t_rgb      r_p5_tex;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rv[c] = 41'(r_p4_r[c]) * 41'($signed(r_p4_v[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_rv   <= rv;
            r_p5_ab2  <= 32'(r_p4_ab) * 32'(r_p4_ab);
            r_p5_diff <= r_p4_diff;
            r_p5_oks  <= r_p4_oks;
            r_p5_tex  <= r_p4_tex;
        end
    end

    // p6: r.v sum, attenuation rounding
    logic signed [42:0] r_p6_rv;
    logic [15:0]        r_p6_att, r_p6_diff;
    logic               r_p6_oks;
    pfs_pkg::t_rgb      r_p6_tex;
    logic [32:0]        att_sum;

    assign att_sum = {1'b0, r_p5_ab2} + 33'(pfs_pkg::ROUND_Q15);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p6_rv   <= 43'(r_p5_rv[0]) + 43'(r_p5_rv[1]) + 43'(r_p5_rv[2]);
            r_p6_att  <= att_sum[30:15];
            r_p6_diff <= r_p5_diff;
            r_p6_oks  <= r_p5_oks;
            r_p6_tex  <= r_p5_tex;
        end
    end

    // p7: specular base clamp, diffuse times attenuation
    logic [15:0]   spec0;
    logic [15:0]   r_p7_spec;
    logic [31:0]   r_p7_da;
    pfs_pkg::t_rgb r_p7_tex;

    always_comb begin
        if (!r_p6_oks || r_p6_rv <= 0) begin
            spec0 = '0;
        end else if (r_p6_rv[42:15] > 28'(pfs_pkg::Q15_ONE)) begin
            spec0 = 16'(pfs_pkg::Q15_ONE);
        end else begin
            spec0 = r_p6_rv[30:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p7_spec <= spec0;
            r_p7_da   <= 32'(r_p6_diff) * 32'(r_p6_att);
            r_p7_tex  <= r_p6_tex;
        end
    end

    // p8..p14: seven rounded squarings for the 128th power, factor alongside
    logic [15:0]   r_sp [Sq];
    pfs_pkg::t_rgb r_tx [Sq];
    logic [31:0]   r_f1;
    logic [14:0]   r_fac [Sq-1];

    for (genvar k = 0; k < Sq; k++) begin : g_spec
        logic [15:0]   sp_in;
        pfs_pkg::t_rgb tx_in;
        logic [31:0]   sqr;

        if (k == 0) begin : g_first
            assign sp_in = r_p7_spec, tx_in = r_p7_tex;
        end else begin : g_next
            assign sp_in = r_sp[k-1], tx_in = r_tx[k-1];
        end

        assign sqr = 32'(sp_in) * 32'(sp_in) + 32'(pfs_pkg::ROUND_Q15);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sp[k] <= sqr[30:15];
                r_tx[k] <= tx_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1     <= 32'(r_p7_da[31:15]) * 32'(pfs_pkg::DIFF_GAIN_Q15);
            r_fac[0] <= 15'(pfs_pkg::AMBIENT_Q15) + 15'(r_f1[31:15]);
            for (int i = 1; i < Sq - 1; i++) begin
                r_fac[i] <= r_fac[i-1];
            end
        end
    end

    // p15: accumulate per channel
    logic [23:0] r_acc [3];
    logic [23:0] spec_add;

    assign spec_add = (24'(r_sp[Sq-1]) * 24'd255) >> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= 24'(r_tx[Sq-1][c]) * 24'(r_fac[Sq-2]) + spec_add;
            end
        end
    end

    // p16: round and saturate into the output register
    logic [24:0]        rnd [3];
    logic [2:0][7:0]    chan;
    pfs_pkg::t_out_item r_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rnd[c] = {1'b0, r_acc[c]} + 25'(pfs_pkg::ROUND_Q15);
            chan[c] = (rnd[c][24:15] > 10'd255) ? 8'd255 : rnd[c][22:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_r <= chan[0];
            r_out.out_g <= chan[1];
            r_out.out_b <= chan[2];
        end
    end

    assign o_out.data = r_out;

    // a zero light vector must leave the normalizer as a zero vector
    a_zero_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[IdxUnit] && l_sum == '0) |-> (l_u == '0))
        else $error("zero light vector not zeroed");

    // attenuation stays within one in Q15
    a_atten_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IdxP6] |-> (r_p6_att <= 16'(pfs_pkg::Q15_ONE)))
        else $error("attenuation above one");

    // lighting factor between ambient and ambient plus full diffuse gain
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IdxP9] |-> (r_fac[0] >= 15'(pfs_pkg::AMBIENT_Q15) &&
            r_fac[0] <= 15'(pfs_pkg::AMBIENT_Q15 + pfs_pkg::DIFF_GAIN_Q15)))
        else $error("lighting factor out of range");

    // specular power stays within one in Q15
    a_spec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IdxP14] |-> (r_sp[Sq-1] <= 16'(pfs_pkg::Q15_ONE)))
        else $error("specular above one");

    // a held output word freezes the valid bits at the input, the normalizer output and the output
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(r_vld[0]) && $stable(r_vld[IdxUnit])
            && $stable(r_vld[Lat-1])))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[hdl/pfs_norm.sv]
// pipelined vector normalizer: sum of squares, digit-by-digit square root, restoring divide
`default_nettype none

module pfs_norm (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire pfs_pkg::t_vec i_a,
    output pfs_pkg::t_vec      o_u,
    output logic [33:0]        o_sum
);

    localparam int SqSteps  = 25;
    localparam int DivSteps = 16;

    // squares and sum
    logic signed [33:0] sq [3];
    logic [31:0]        r_sq [3];
    pfs_pkg::t_vec      r_a1, r_a2;
    logic [33:0]        r_s;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sq[c] = $signed(i_a[c]) * $signed(i_a[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= sq[c][31:0];
            end
            r_a1 <= i_a;
            r_a2 <= r_a1;
            r_s  <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        end
    end

    // square root of sum * 2^16, one result bit per stage
    logic [27:0]   r_rem [SqSteps];
    logic [24:0]   r_res [SqSteps];
    logic [33:0]   r_ss  [SqSteps];
    pfs_pkg::t_vec r_av  [SqSteps];

    for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
        logic [27:0]   rem_in, rem_sh, trial;
        logic [24:0]   res_in;
        logic [33:0]   s_in;
        pfs_pkg::t_vec a_in;
        logic [49:0]   xw;

        if (j == 0) begin : g_first
            assign rem_in = '0, res_in = '0, s_in = r_s, a_in = r_a2;
        end else begin : g_next
            assign rem_in = r_rem[j-1], res_in = r_res[j-1], s_in = r_ss[j-1],
                   a_in = r_av[j-1];
        end

        assign xw     = {s_in, 16'b0};
        assign rem_sh = {rem_in[25:0], xw[49-2*j -: 2]};
        assign trial  = {1'b0, res_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ss[j] <= s_in;
                r_av[j] <= a_in;
                if (rem_sh >= trial) begin
                    r_rem[j] <= rem_sh - trial;
                    r_res[j] <= {res_in[23:0], 1'b1};
                end else begin
                    r_rem[j] <= rem_sh;
                    r_res[j] <= {res_in[23:0], 1'b0};
                end
            end
        end
    end

    // divide setup: magnitudes scaled by 2^23
    logic [39:0] r_d0_num [3];
    logic [2:0]  r_d0_neg;
    logic [24:0] r_d0_len;
    logic [33:0] r_d0_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_av[SqSteps-1][c][16]) begin
                    r_d0_num[c] <= {1'b0, 16'(-$signed(r_av[SqSteps-1][c])), 23'b0};
                end else begin
                    r_d0_num[c] <= {1'b0, r_av[SqSteps-1][c][15:0], 23'b0};
                end
                r_d0_neg[c] <= r_av[SqSteps-1][c][16];
            end
            r_d0_len <= r_res[SqSteps-1];
            r_d0_sum <= r_ss[SqSteps-1];
        end
    end

    // restoring divide, one quotient bit per stage, quotient below 2^16
    logic [39:0] r_dn  [DivSteps][3];
    logic [15:0] r_dq  [DivSteps][3];
    logic [24:0] r_dlen [DivSteps];
    logic [2:0]  r_dneg [DivSteps];
    logic [33:0] r_dsum [DivSteps];

    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        logic [39:0] num_in [3];
        logic [15:0] q_in   [3];
        logic [24:0] len_in;
        logic [2:0]  neg_in;
        logic [33:0] sum_in;
        logic [39:0] dvs;

        if (g == 0) begin : g_first
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    num_in[c] = r_d0_num[c];
                    q_in[c]   = '0;
                end
                len_in = r_d0_len;
                neg_in = r_d0_neg;
                sum_in = r_d0_sum;
            end
        end else begin : g_next
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    num_in[c] = r_dn[g-1][c];
                    q_in[c]   = r_dq[g-1][c];
                end
                len_in = r_dlen[g-1];
                neg_in = r_dneg[g-1];
                sum_in = r_dsum[g-1];
            end
        end

        assign dvs = {15'b0, len_in} << (DivSteps - 1 - g);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    if (num_in[c] >= dvs) begin
                        r_dn[g][c] <= num_in[c] - dvs;
                        r_dq[g][c] <= q_in[c] | (16'd1 << (DivSteps - 1 - g));
                    end else begin
                        r_dn[g][c] <= num_in[c];
                        r_dq[g][c] <= q_in[c];
                    end
                end
                r_dlen[g] <= len_in;
                r_dneg[g] <= neg_in;
                r_dsum[g] <= sum_in;
            end
        end
    end

    // sign and zero-vector handling
    pfs_pkg::t_vec r_u;
    logic [33:0]   r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_dsum[DivSteps-1] == '0) begin
                    r_u[c] <= '0;
                end else if (r_dneg[DivSteps-1][c]) begin
                    r_u[c] <= -{1'b0, r_dq[DivSteps-1][c]};
                end else begin
                    r_u[c] <= {1'b0, r_dq[DivSteps-1][c]};
                end
            end
            r_sum <= r_dsum[DivSteps-1];
        end
    end

    assign o_u   = r_u;
    assign o_sum = r_sum;

endmodule

`default_nettype wire
